FILE: rtl/assert_macros.svh
// Assertion macros shared by the calendar date advancer RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/cdate_pkg.sv
// Shared types, constants and calendar functions for the date advancer.
// No dependencies; used by the interfaces, the remainder unit and the top level.
package cdate_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned COUNT_W = 16;

  localparam int unsigned MAX_YEAR      = 65535;
  localparam int unsigned MAX_STEP_DAYS = 65535;
  localparam int unsigned STEP_W        = $clog2(MAX_STEP_DAYS + 1);

  // Leap rule period and its sub-periods
  localparam int unsigned LEAP_CYCLE = 400;
  localparam int unsigned CENTURY    = 100;
  localparam int unsigned REM_W      = $clog2(LEAP_CYCLE);

  localparam int unsigned MONTHS     = 12;
  localparam int unsigned DAYS_LONG  = 31;
  localparam int unsigned DAYS_SHORT = 30;
  localparam int unsigned DAYS_FEB   = 28;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic [COUNT_W-1:0] day_count;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   cur_day;
    logic [MONTH_W-1:0] cur_month;
    logic [YEAR_W-1:0]  cur_year;
    logic               load_rejected;
    logic               year_overflow;
  } rsp_t;

  // Leap test from year mod 400 and the two low bits of the year
  function automatic logic is_leap(input logic [REM_W-1:0] rem400,
                                   input logic [1:0]       low2);
    logic century;
    century = (rem400 == REM_W'(CENTURY)) || (rem400 == REM_W'(2 * CENTURY)) ||
              (rem400 == REM_W'(3 * CENTURY));
    return (rem400 == '0) || (!century && (low2 == 2'b00));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic               leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(DAYS_SHORT);
      4'd2:                    len = leap ? DAY_W'(DAYS_FEB + 1) : DAY_W'(DAYS_FEB);
      default:                 len = DAY_W'(DAYS_LONG);
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/cdate_if.sv
// Valid/ready channel interfaces for requests and results of the date advancer.
// Depends on cdate_pkg for the payload types.
interface cdate_req_if;
  logic              valid;
  logic              ready;
  cdate_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cdate_rsp_if;
  logic              valid;
  logic              ready;
  cdate_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cdate_rem400.sv
// Remainder unit: year mod 400 by reciprocal multiplication; requests may overlap.
// Depends on cdate_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdate_rem400 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [cdate_pkg::YEAR_W-1:0]  dividend_i,
  output logic                          done_o,
  output logic [cdate_pkg::REM_W-1:0]   rem_o
);

  // ceil(2^25 / 400) gives the exact quotient for every 16-bit year
  localparam int unsigned RECIP_SH = 25;
  localparam int unsigned RECIP    = ((2 ** RECIP_SH) + cdate_pkg::LEAP_CYCLE - 1) /
                                     cdate_pkg::LEAP_CYCLE;
  localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned PROD_W   = cdate_pkg::YEAR_W + RECIP_W;
  localparam int unsigned Q_W      = $clog2(cdate_pkg::MAX_YEAR / cdate_pkg::LEAP_CYCLE + 1);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic                         stage_v_r, stage_v_nxt;
  logic                         done_r, done_nxt;
  logic [cdate_pkg::YEAR_W-1:0] dividend_r, dividend_nxt;
  logic [Q_W-1:0]               quot_r, quot_nxt;
  logic [cdate_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [PROD_W-1:0]            prod;
  logic [cdate_pkg::YEAR_W-1:0] back;

  // Quotient from the reciprocal product, then multiply back by the divisor
  assign prod = PROD_W'(dividend_i) * PROD_W'(RECIP_C);
  assign back = cdate_pkg::YEAR_W'(quot_r) * cdate_pkg::YEAR_W'(cdate_pkg::LEAP_CYCLE);

  always_comb begin
    stage_v_nxt  = start_i;
    done_nxt     = stage_v_r;
    dividend_nxt = dividend_r;
    quot_nxt     = quot_r;
    rem_nxt      = rem_r;
    if (start_i) begin
      dividend_nxt = dividend_i;
      quot_nxt     = Q_W'(prod >> RECIP_SH);
    end
    if (stage_v_r) begin
      rem_nxt = cdate_pkg::REM_W'(dividend_r - back);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      done_r    <= 1'b0;
      rem_r     <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
      done_r    <= done_nxt;
      rem_r     <= rem_nxt;
    end
    dividend_r <= dividend_nxt;
    quot_r     <= quot_nxt;
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

  `ASSERT_ALWAYS(a_rem_bound, rem_r < cdate_pkg::REM_W'(cdate_pkg::LEAP_CYCLE))
  `ASSERT_IMPLY(a_quot_bound, stage_v_r, quot_r <= Q_W'(cdate_pkg::MAX_YEAR / cdate_pkg::LEAP_CYCLE))
  `ASSERT_NEXT(a_stage_after_start, start_i, stage_v_r)
  `ASSERT_NEXT(a_done_after_stage, stage_v_r, done_r)

endmodule

FILE: rtl/calendar_date_advancer_top.sv
// A load goes through the remainder unit for the leap check before its result is
// registered; an advance by n days steps min(n, MAX_STEP_DAYS) days, fewer if it
// stops at 31/12 of MAX_YEAR. One day is stepped per cycle by the sequencer.
// One request is in flight at a time; the next is taken once the result is delivered.
// Reset (synchronous, rst_n low) sets the date to 1/1/2000 and clears the channels.
// Depends on cdate_pkg, cdate_if, cdate_rem400 and assert_macros.svh.
`include "assert_macros.svh"

module calendar_date_advancer_top (
  input  logic        clk,
  input  logic        rst_n,
  cdate_req_if.sink   in_req,
  cdate_rsp_if.source out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_STEP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cdate_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [cdate_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [cdate_pkg::YEAR_W-1:0]  year_r, year_nxt;
  logic [cdate_pkg::REM_W-1:0]   r400_r, r400_nxt;
  logic [cdate_pkg::DAY_W-1:0]   ld_day_r, ld_day_nxt;
  logic [cdate_pkg::MONTH_W-1:0] ld_month_r, ld_month_nxt;
  logic [cdate_pkg::YEAR_W-1:0]  ld_year_r, ld_year_nxt;
  logic [cdate_pkg::STEP_W-1:0]  left_r, left_nxt;
  cdate_pkg::rsp_t               rsp_r, rsp_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          in_ready;
  logic                          rem_start;
  logic                          rem_done;
  logic [cdate_pkg::REM_W-1:0]   rem_val;
  logic [cdate_pkg::DAY_W-1:0]   cur_len;
  logic [cdate_pkg::DAY_W-1:0]   ld_len;
  logic                          ld_ok;

  // Remainder unit for the leap test of a loaded year
  cdate_rem400 u_rem (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (rem_start),
    .dividend_i (in_req.payload.new_year),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Month lengths for the held date and for the pending load
  assign cur_len = cdate_pkg::month_len(month_r, cdate_pkg::is_leap(r400_r, year_r[1:0]));
  assign ld_len  = cdate_pkg::month_len(ld_month_r, cdate_pkg::is_leap(rem_val, ld_year_r[1:0]));
  assign ld_ok   = (ld_month_r >= cdate_pkg::MONTH_W'(1)) &&
                   (ld_month_r <= cdate_pkg::MONTH_W'(cdate_pkg::MONTHS)) &&
                   (ld_day_r >= cdate_pkg::DAY_W'(1)) && (ld_day_r <= ld_len) &&
                   (32'(ld_year_r) <= cdate_pkg::MAX_YEAR);

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    r400_nxt      = r400_r;
    ld_day_nxt    = ld_day_r;
    ld_month_nxt  = ld_month_r;
    ld_year_nxt   = ld_year_r;
    left_nxt      = left_r;
    rsp_nxt       = rsp_r;
    out_valid_nxt = out_valid_r;
    rem_start     = 1'b0;

    // Drop the result once it is taken
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid && in_ready) begin
          ld_day_nxt   = in_req.payload.new_day;
          ld_month_nxt = in_req.payload.new_month;
          ld_year_nxt  = in_req.payload.new_year;
          if (in_req.payload.command == cdate_pkg::CMD_LOAD) begin
            rem_start = 1'b1;
            state_nxt = S_REM;
          end else begin
            left_nxt  = (32'(in_req.payload.day_count) > cdate_pkg::MAX_STEP_DAYS)
                        ? cdate_pkg::STEP_W'(cdate_pkg::MAX_STEP_DAYS)
                        : cdate_pkg::STEP_W'(in_req.payload.day_count);
            state_nxt = S_STEP;
          end
        end
      end

      // Check the loaded date once the leap remainder is ready
      S_REM: begin
        if (rem_done) begin
          rsp_nxt.load_rejected = !ld_ok;
          rsp_nxt.year_overflow = 1'b0;
          if (ld_ok) begin
            day_nxt   = ld_day_r;
            month_nxt = ld_month_r;
            year_nxt  = ld_year_r;
            r400_nxt  = rem_val;
            rsp_nxt.cur_day   = ld_day_r;
            rsp_nxt.cur_month = ld_month_r;
            rsp_nxt.cur_year  = ld_year_r;
          end else begin
            rsp_nxt.cur_day   = day_r;
            rsp_nxt.cur_month = month_r;
            rsp_nxt.cur_year  = year_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Advance one day per cycle, stop at the end of the calendar
      S_STEP: begin
        rsp_nxt.cur_day       = day_r;
        rsp_nxt.cur_month     = month_r;
        rsp_nxt.cur_year      = year_r;
        rsp_nxt.load_rejected = 1'b0;
        rsp_nxt.year_overflow = 1'b0;
        if (left_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (day_r >= cur_len) begin
          if (month_r >= cdate_pkg::MONTH_W'(cdate_pkg::MONTHS)) begin
            if (32'(year_r) >= cdate_pkg::MAX_YEAR) begin
              rsp_nxt.year_overflow = 1'b1;
              out_valid_nxt         = 1'b1;
              state_nxt             = S_IDLE;
            end else begin
              day_nxt   = cdate_pkg::DAY_W'(1);
              month_nxt = cdate_pkg::MONTH_W'(1);
              year_nxt  = year_r + cdate_pkg::YEAR_W'(1);
              r400_nxt  = (r400_r == cdate_pkg::REM_W'(cdate_pkg::LEAP_CYCLE - 1))
                          ? '0 : r400_r + cdate_pkg::REM_W'(1);
              left_nxt  = left_r - cdate_pkg::STEP_W'(1);
            end
          end else begin
            day_nxt   = cdate_pkg::DAY_W'(1);
            month_nxt = month_r + cdate_pkg::MONTH_W'(1);
            left_nxt  = left_r - cdate_pkg::STEP_W'(1);
          end
        end else begin
          day_nxt  = day_r + cdate_pkg::DAY_W'(1);
          left_nxt = left_r - cdate_pkg::STEP_W'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      day_r       <= cdate_pkg::DAY_W'(1);
      month_r     <= cdate_pkg::MONTH_W'(1);
      year_r      <= cdate_pkg::YEAR_W'(2000);
      r400_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      r400_r      <= r400_nxt;
    end
    ld_day_r   <= ld_day_nxt;
    ld_month_r <= ld_month_nxt;
    ld_year_r  <= ld_year_nxt;
    left_r     <= left_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.payload = rsp_r;

  `ASSERT_ALWAYS(a_month_range, (month_r >= cdate_pkg::MONTH_W'(1)) && (month_r <= cdate_pkg::MONTH_W'(cdate_pkg::MONTHS)))
  `ASSERT_ALWAYS(a_day_range, (day_r >= cdate_pkg::DAY_W'(1)) && (day_r <= cur_len))
  `ASSERT_IMPLY(a_rem_done_in_load, rem_done, state_r == S_REM)
  `ASSERT_IMPLY(a_overflow_at_end, out_valid_r && rsp_r.year_overflow, (rsp_r.cur_day == cdate_pkg::DAY_W'(cdate_pkg::DAYS_LONG)) && (rsp_r.cur_month == cdate_pkg::MONTH_W'(cdate_pkg::MONTHS)))

endmodule

FILE: bench/tb.sv
// Self-checking bench for calendar_date_advancer_top: directed rows, then random requests.
// Depends on cdate_pkg and cdate_if from the RTL; predicts each result in-bench unless a directed row gives it.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 75;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct {
    cdate_pkg::req_t req;
    bit              typed;
    cdate_pkg::rsp_t want;
  } date_vector_t;

  logic clk;
  logic rst_n = 1'b0;

  cdate_req_if req_ch ();
  cdate_rsp_if rsp_ch ();

  calendar_date_advancer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // Predicted calendar state
  logic [cdate_pkg::DAY_W-1:0]   cal_day;
  logic [cdate_pkg::MONTH_W-1:0] cal_month;
  logic [cdate_pkg::YEAR_W-1:0]  cal_year;

  cdate_pkg::rsp_t pending_dates[$];
  date_vector_t    directed_rows[$];
  int unsigned     mismatch_count = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  bit              hold_results   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_year(input logic [cdate_pkg::YEAR_W-1:0] y);
    int unsigned yr;
    yr = 32'(y);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(input logic [cdate_pkg::MONTH_W-1:0] m,
                                                input logic [cdate_pkg::YEAR_W-1:0]  y);
    int unsigned len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      4'd2:                    len = leap_year(y) ? 29 : 28;
      default:                 len = 31;
    endcase
    return len;
  endfunction

  // Apply one request to the predicted date and return the result it gives
  function automatic cdate_pkg::rsp_t step_calendar(input cdate_pkg::req_t r);
    cdate_pkg::rsp_t res;
    int unsigned     left;
    res = '0;
    if (r.command == cdate_pkg::CMD_LOAD) begin
      if (r.new_month >= 1 && r.new_month <= 12 && r.new_day >= 1 &&
          r.new_day <= days_in_month(r.new_month, r.new_year)) begin
        cal_day   = r.new_day;
        cal_month = r.new_month;
        cal_year  = r.new_year;
      end else begin
        res.load_rejected = 1'b1;
      end
    end else begin
      left = 32'(r.day_count);
      if (left > cdate_pkg::MAX_STEP_DAYS) left = cdate_pkg::MAX_STEP_DAYS;
      while (left > 0) begin
        if (cal_day >= days_in_month(cal_month, cal_year)) begin
          if (cal_month >= 12) begin
            // stop at the last day of the calendar
            if (cal_year >= cdate_pkg::YEAR_W'(cdate_pkg::MAX_YEAR)) begin
              res.year_overflow = 1'b1;
              break;
            end
            cal_day   = cdate_pkg::DAY_W'(1);
            cal_month = cdate_pkg::MONTH_W'(1);
            cal_year  = cal_year + 1'b1;
          end else begin
            cal_day   = cdate_pkg::DAY_W'(1);
            cal_month = cal_month + 1'b1;
          end
        end else begin
          cal_day = cal_day + 1'b1;
        end
        left--;
      end
    end
    res.cur_day   = cal_day;
    res.cur_month = cal_month;
    res.cur_year  = cal_year;
    return res;
  endfunction

  task automatic add_vector(input logic cmd, input int d, input int m, input int y,
                            input int cnt, input bit typed, input int ed, input int em,
                            input int ey, input bit rej, input bit ovf);
    date_vector_t v;
    v.req.command           = cmd;
    v.req.new_day           = cdate_pkg::DAY_W'(d);
    v.req.new_month         = cdate_pkg::MONTH_W'(m);
    v.req.new_year          = cdate_pkg::YEAR_W'(y);
    v.req.day_count         = cdate_pkg::COUNT_W'(cnt);
    v.typed                 = typed;
    v.want.cur_day          = cdate_pkg::DAY_W'(ed);
    v.want.cur_month        = cdate_pkg::MONTH_W'(em);
    v.want.cur_year         = cdate_pkg::YEAR_W'(ey);
    v.want.load_rejected    = rej;
    v.want.year_overflow    = ovf;
    directed_rows.push_back(v);
  endtask

  // Mostly valid loads and short advances; a long advance every 25th request
  function automatic cdate_pkg::req_t random_request(input int unsigned idx);
    cdate_pkg::req_t r;
    int unsigned     sel;
    int unsigned     len;
    r.command   = cdate_pkg::CMD_LOAD;
    r.new_day   = cdate_pkg::DAY_W'($urandom());
    r.new_month = cdate_pkg::MONTH_W'($urandom());
    r.new_year  = cdate_pkg::YEAR_W'($urandom());
    r.day_count = cdate_pkg::COUNT_W'($urandom());
    sel = $urandom_range(99);
    if (idx % 25 == 24) begin
      r.command = cdate_pkg::CMD_ADVANCE;
    end else if (sel < 45) begin
      r.command   = cdate_pkg::CMD_ADVANCE;
      r.day_count = $urandom_range(1) ? cdate_pkg::COUNT_W'($urandom_range(3))
                                      : cdate_pkg::COUNT_W'($urandom_range(400));
    end else if (sel < 85) begin
      case ($urandom_range(3))
        0:       r.new_year = cdate_pkg::YEAR_W'($urandom_range(65535));
        1:       r.new_year = cdate_pkg::YEAR_W'(100 * $urandom_range(655));
        2:       r.new_year = cdate_pkg::YEAR_W'($urandom_range(65535, 65530));
        default: r.new_year = cdate_pkg::YEAR_W'($urandom_range(2100, 1896));
      endcase
      r.new_month = cdate_pkg::MONTH_W'($urandom_range(12, 1));
      len = days_in_month(r.new_month, r.new_year);
      r.new_day = $urandom_range(1) ? cdate_pkg::DAY_W'(len)
                                    : cdate_pkg::DAY_W'($urandom_range(len, 1));
    end
    return r;
  endfunction

  // Offer one request; record its expected result when it is taken
  task automatic send_request(input cdate_pkg::req_t r, input bit typed,
                              input cdate_pkg::rsp_t want);
    cdate_pkg::rsp_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = step_calendar(r);
    pending_dates.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each delivered result against the oldest expectation
  always @(posedge clk) begin
    cdate_pkg::rsp_t want;
    cdate_pkg::rsp_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result %0d/%0d/%0d rej=%0b ovf=%0b", got.cur_day,
                   got.cur_month, got.cur_year, got.load_rejected, got.year_overflow);
      end else begin
        want = pending_dates.pop_front();
        if (got.cur_day !== want.cur_day || got.cur_month !== want.cur_month ||
            got.cur_year !== want.cur_year || got.load_rejected !== want.load_rejected ||
            got.year_overflow !== want.year_overflow) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("expected %0d/%0d/%0d rej=%0b ovf=%0b, got %0d/%0d/%0d rej=%0b ovf=%0b",
                     want.cur_day, want.cur_month, want.cur_year, want.load_rejected,
                     want.year_overflow, got.cur_day, got.cur_month, got.cur_year,
                     got.load_rejected, got.year_overflow);
        end
      end
    end
  end

  // Stimulus
  initial begin
    cdate_pkg::req_t r;
    cdate_pkg::rsp_t none;
    none = '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cal_day   = cdate_pkg::DAY_W'(1);
    cal_month = cdate_pkg::MONTH_W'(1);
    cal_year  = cdate_pkg::YEAR_W'(2000);

    // Directed rows: typed expectations where obvious, otherwise predicted
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1, 1, 1, 2000, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 29, 2, 2000, 0, 1, 29, 2, 2000, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 1, 1, 1, 3, 2000, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 29, 2, 1900, 0, 1, 1, 3, 2000, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 29, 2, 2024, 0, 1, 29, 2, 2024, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 31, 4, 2024, 0, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 0, 5, 2024, 0, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 1, 0, 2024, 0, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 1, 13, 2024, 0, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 31, 15, 65535, 65535, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 0, 0, 0, 0, 1, 29, 2, 2024, 1, 0);
    add_vector(cdate_pkg::CMD_LOAD, 1, 1, 0, 0, 1, 1, 1, 0, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 59, 0, 0, 0, 0, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 31, 12, 2023, 0, 1, 31, 12, 2023, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 1, 1, 1, 1, 2024, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 28, 2, 2100, 0, 1, 28, 2, 2100, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 1, 1, 1, 3, 2100, 0, 0);
    add_vector(cdate_pkg::CMD_LOAD, 31, 12, 65535, 0, 1, 31, 12, 65535, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1, 31, 12, 65535, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 1, 1, 31, 12, 65535, 0, 1);
    add_vector(cdate_pkg::CMD_LOAD, 1, 12, 65535, 0, 1, 1, 12, 65535, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 31, 15, 65535, 65535, 1, 31, 12, 65535, 0, 1);
    add_vector(cdate_pkg::CMD_LOAD, 31, 1, 2001, 0, 1, 31, 1, 2001, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 65535, 0, 0, 0, 0, 0, 0);
    add_vector(cdate_pkg::CMD_ADVANCE, 0, 0, 0, 400, 0, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender sparse gaps, receiver mostly stalled
    send_idle_pct  = 10;
    recv_stall_pct = 87;
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        // Swap idling sides; hold results off while requests keep coming
        wait_for_results();
        send_idle_pct  = 87;
        recv_stall_pct = 10;
        hold_results   = 1'b1;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_for_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      r = random_request(n);
      send_request(r, 1'b0, none);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("calendar_date_advancer_top: match");
    end else begin
      $display("calendar_date_advancer_top: mismatch");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #40000000;
    $display("calendar_date_advancer_top: mismatch");
    $finish;
  end

endmodule
